FILE: sv/plist_pkg.sv
`timescale 1ns / 1ps

package plist_pkg;

    localparam int CAPACITY      = 64;
    localparam int ELEMENT_WIDTH = 32;
    localparam int ADDR_W        = $clog2(CAPACITY);
    localparam int CNT_W         = $clog2(CAPACITY + 1);
    localparam int POS_W         = 8;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CHK,
        ST_INS_WR,
        ST_REM_WAIT,
        ST_REM_CHK,
        ST_REM_WR,
        ST_RD_WAIT
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         pos;
        logic [ELEMENT_WIDTH-1:0] elem;
    } cmd_t;

    typedef struct packed {
        logic                     valid;
        logic [ELEMENT_WIDTH-1:0] elem;
        logic [CNT_W-1:0]         count;
        status_t                  status;
    } fin_t;

endpackage

FILE: sv/plist_ram.sv
`timescale 1ns / 1ps

module plist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/plist_seq.sv
`timescale 1ns / 1ps

module plist_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  plist_pkg::cmd_t cmd,
    output logic          busy,
    output plist_pkg::fin_t fin
);

    import plist_pkg::*;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         lim_reg, lim_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [ELEMENT_WIDTH-1:0] elem_reg, elem_next;
    logic [ELEMENT_WIDTH-1:0] got_reg, got_next;

    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic [ELEMENT_WIDTH-1:0] wdata;
    logic [ADDR_W-1:0]        raddr;
    logic [ELEMENT_WIDTH-1:0] rdata;

    logic                     step_down;
    logic [CNT_W-1:0]         idx_sum;
    logic [POS_W-1:0]         count_ext;
    logic [CNT_W-1:0]         ins_lim;
    logic [CNT_W-1:0]         rem_lim;

    plist_ram #(
        .WIDTH(ELEMENT_WIDTH),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    // shared index stepper: down while opening a gap, up while closing one
    assign step_down = (state_reg == ST_INS_CHK) || (state_reg == ST_INS_WR);
    assign idx_sum   = step_down ? idx_reg - CNT_W'(1) : idx_reg + CNT_W'(1);

    assign count_ext = POS_W'(count_reg);
    assign ins_lim   = (cmd.pos > count_ext) ? count_reg : CNT_W'(cmd.pos);
    assign rem_lim   = (cmd.pos >= count_ext) ? count_reg - CNT_W'(1) : CNT_W'(cmd.pos);

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        lim_reg  <= lim_next;
        elem_reg <= elem_next;
        got_reg  <= got_next;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        lim_next   = lim_reg;
        count_next = count_reg;
        elem_next  = elem_reg;
        got_next   = got_reg;
        we         = 1'b0;
        waddr      = idx_reg[ADDR_W-1:0];
        wdata      = rdata;
        raddr      = idx_sum[ADDR_W-1:0];
        fin        = '0;
        fin.count  = count_reg;
        fin.status = STAT_OK;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.op)
                        OP_INSERT:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                fin.valid  = 1'b1;
                                fin.status = STAT_FULL;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                lim_next   = ins_lim;
                                elem_next  = cmd.elem;
                                state_next = ST_INS_CHK;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                fin.valid  = 1'b1;
                                fin.status = STAT_EMPTY;
                            end
                            else
                            begin
                                raddr      = rem_lim[ADDR_W-1:0];
                                idx_next   = rem_lim;
                                state_next = ST_REM_WAIT;
                            end
                        end
                        OP_READ:
                        begin
                            if (cmd.pos >= count_ext)
                            begin
                                fin.valid  = 1'b1;
                                fin.status = STAT_RANGE;
                            end
                            else
                            begin
                                raddr      = cmd.pos[ADDR_W-1:0];
                                state_next = ST_RD_WAIT;
                            end
                        end
                        default:
                        begin
                            fin.valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_INS_CHK:
            begin
                if (idx_reg > lim_reg)
                begin
                    state_next = ST_INS_WR;
                end
                else
                begin
                    // gap is open: drop the new element into it
                    we         = 1'b1;
                    wdata      = elem_reg;
                    count_next = count_reg + CNT_W'(1);
                    fin.valid  = 1'b1;
                    fin.count  = count_next;
                    state_next = ST_IDLE;
                end
            end
            ST_INS_WR:
            begin
                we         = 1'b1;
                idx_next   = idx_sum;
                state_next = ST_INS_CHK;
            end
            ST_REM_WAIT:
            begin
                got_next   = rdata;
                state_next = ST_REM_CHK;
            end
            ST_REM_CHK:
            begin
                if (idx_sum < count_reg)
                begin
                    state_next = ST_REM_WR;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    fin.valid  = 1'b1;
                    fin.elem   = got_reg;
                    fin.count  = count_next;
                    state_next = ST_IDLE;
                end
            end
            ST_REM_WR:
            begin
                we         = 1'b1;
                idx_next   = idx_sum;
                state_next = ST_REM_CHK;
            end
            ST_RD_WAIT:
            begin
                fin.valid  = 1'b1;
                fin.elem   = rdata;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/positional_list_engine.sv
`timescale 1ns / 1ps

// Bounded ordered list of element handles, up to CAPACITY entries in one RAM.
// Command channel: drive op, position and element with start high; the item
// is taken at the rising edge where start is high and busy is low.
// Result channel: done pulses high for exactly one cycle with element_out,
// count_out and status. There is no backpressure; the receiver must take the
// item in that cycle.
// Sequence from the accepted item to done: a refused request (full, empty,
// out of range) or unused op is answered straight from idle; a read waits
// for the registered RAM read; an insert alternates a check state and a
// write state for each entry moved (count - position, after clamping), then
// writes the new element; a remove waits for the RAM read of the removed
// entry, then alternates check and write for each entry moved (count -
// position - 1, after clamping). Each moved entry costs one RAM read plus
// one RAM write through the single read and write ports, stepped by one
// shared index adder. busy falls in the done cycle, so the next item may be
// taken at the edge that ends it; no new item is taken until then.
// Reset clears the element count and returns the sequencer to idle; RAM
// contents are left as they are and only entries below count are ever used.
module positional_list_engine (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [plist_pkg::OP_W-1:0]           op,
    input  logic [plist_pkg::POS_W-1:0]          position,
    input  logic [plist_pkg::ELEMENT_WIDTH-1:0]  element,
    output logic                                 done,
    output logic [plist_pkg::ELEMENT_WIDTH-1:0]  element_out,
    output logic [plist_pkg::CNT_W-1:0]          count_out,
    output logic [plist_pkg::STATUS_W-1:0]       status
);

    import plist_pkg::*;

    logic  accept;
    cmd_t  cmd;
    fin_t  fin;
    logic  seq_busy;

    logic                     done_reg;
    logic [ELEMENT_WIDTH-1:0] element_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [STATUS_W-1:0]      status_reg;

    // take a new item only while the sequencer sits idle
    assign accept   = start && !seq_busy;
    assign busy     = seq_busy;
    assign cmd.op   = op;
    assign cmd.pos  = position;
    assign cmd.elem = element;

    plist_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .accept(accept),
        .cmd   (cmd),
        .busy  (seq_busy),
        .fin   (fin)
    );

    // hold the strobe for one cycle; payload follows it, no reset needed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin.valid)
        begin
            element_reg <= fin.elem;
            count_reg   <= fin.count;
            status_reg  <= fin.status;
        end
    end

    assign done        = done_reg;
    assign element_out = element_reg;
    assign count_out   = count_reg;
    assign status      = status_reg;

endmodule

FILE: sim/tb_positional_list_engine.sv
`timescale 1ns / 1ps

module tb_positional_list_engine;

    import plist_pkg::*;

    // Longest accept-free stretch of a correct run: a remove at the head of a
    // full list plus a few sender idle cycles. Allow plenty.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to keep watching for stray results once everything has drained.
    localparam int DRAIN_CYCLES   = 150;
    localparam int TOTAL_ITEMS    = 1050;

    typedef struct {
        op_t                      op;
        logic [POS_W-1:0]         pos;
        logic [ELEMENT_WIDTH-1:0] elem;
    } list_req_t;

    typedef struct {
        logic [ELEMENT_WIDTH-1:0] elem;
        logic [CNT_W-1:0]         count;
        status_t                  status;
    } list_reply_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [OP_W-1:0]          op = OP_NONE;
    logic [POS_W-1:0]         position = '0;
    logic [ELEMENT_WIDTH-1:0] element = '0;
    logic                     done;
    logic [ELEMENT_WIDTH-1:0] element_out;
    logic [CNT_W-1:0]         count_out;
    logic [STATUS_W-1:0]      status;

    // Requests waiting to be issued, and replies the list should produce.
    list_req_t   request_q[$];
    list_reply_t reply_q[$];

    // Shadow copy of the list contents and its fill level.
    logic [ELEMENT_WIDTH-1:0] shadow_list[CAPACITY];
    int                       shadow_count = 0;

    int total_requests = 0;
    int accepted       = 0;
    int quiet_cycles   = 0;
    int err_count      = 0;

    positional_list_engine u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .position    (position),
        .element     (element),
        .done        (done),
        .element_out (element_out),
        .count_out   (count_out),
        .status      (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the shadow list and return the reply it should get.
    // Insert past the end appends; remove past the end drops the last entry.
    function automatic list_reply_t apply_list_request(op_t req_op, logic [POS_W-1:0] req_pos,
                                                       logic [ELEMENT_WIDTH-1:0] req_elem);
        list_reply_t r;
        int          p;
        int          i;
        r.elem   = '0;
        r.status = STAT_OK;
        case (req_op)
            OP_INSERT:
            begin
                if (shadow_count >= CAPACITY)
                    r.status = STAT_FULL;
                else
                begin
                    p = (int'(req_pos) > shadow_count) ? shadow_count : int'(req_pos);
                    for (i = shadow_count; i > p; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[p] = req_elem;
                    shadow_count++;
                end
            end
            OP_REMOVE:
            begin
                if (shadow_count == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    p = (int'(req_pos) >= shadow_count) ? shadow_count - 1 : int'(req_pos);
                    r.elem = shadow_list[p];
                    for (i = p; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_count--;
                end
            end
            OP_READ:
            begin
                if (int'(req_pos) >= shadow_count)
                    r.status = STAT_RANGE;
                else
                    r.elem = shadow_list[req_pos];
            end
            default: ;
        endcase
        r.count = shadow_count[CNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [ELEMENT_WIDTH-1:0] got,
                                   logic [ELEMENT_WIDTH-1:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    task automatic queue_request(op_t req_op, logic [POS_W-1:0] req_pos,
                                 logic [ELEMENT_WIDTH-1:0] req_elem);
        list_req_t r;
        r.op   = req_op;
        r.pos  = req_pos;
        r.elem = req_elem;
        request_q.push_back(r);
    endtask

    // Favor the two ends and small positions, but still reach every bit.
    function automatic logic [POS_W-1:0] pick_position();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return '0;
        if (roll < 30)
            return '1;
        if (roll < 70)
            return POS_W'($urandom_range(0, CAPACITY));
        return POS_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [ELEMENT_WIDTH-1:0] pick_element();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return ELEMENT_WIDTH'($urandom);
    endfunction

    // Sender idle odds by stage: moderate idling, heavy idling, then back-to-back.
    function automatic int idle_percent();
        if (accepted < total_requests / 3)
            return 36;
        if (accepted < (2 * total_requests) / 3)
            return 62;
        return 0;
    endfunction

    // Driver: on each edge, first log an item the block just took, then hold
    // the current item, or idle this cycle, or present the next one.
    always @(posedge clk)
    begin : driver
        list_req_t nxt;
        logic      taken;
        logic      show;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                reply_q.push_back(apply_list_request(op_t'(op), position, element));
                accepted++;
            end
            show = start && !taken;
            if (!show && request_q.size() > 0 && $urandom_range(0, 99) >= idle_percent())
            begin
                nxt      = request_q.pop_front();
                op       <= nxt.op;
                position <= nxt.pos;
                element  <= nxt.elem;
                show     = 1'b1;
            end
            start <= show;
        end
    end

    // Monitor: every done pulse must match the oldest outstanding reply.
    // Also run the watchdog here: drop the run if nothing moves for too long.
    always @(posedge clk)
    begin : monitor
        list_reply_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (reply_q.size() == 0)
                    report_mismatch("result with nothing outstanding", element_out, '0);
                else
                begin
                    want = reply_q.pop_front();
                    if (element_out !== want.elem)
                        report_mismatch("element_out", element_out, want.elem);
                    if (count_out !== want.count)
                        report_mismatch("count_out", ELEMENT_WIDTH'(count_out),
                                        ELEMENT_WIDTH'(want.count));
                    if (status !== want.status)
                        report_mismatch("status", ELEMENT_WIDTH'(status),
                                        ELEMENT_WIDTH'(want.status));
                end
            end
            if (done || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("positional_list_engine verification failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int burst_mode;
        int burst_len;
        int roll;
        op_t pick;

        // Directed: empty-list cases, the unused op, appends, head and middle inserts,
        // reads in and past range, removes from middle, tail and head.
        queue_request(OP_READ,   8'd0,   32'h0000_0001);
        queue_request(OP_REMOVE, 8'd0,   32'h0);
        queue_request(OP_READ,   8'd255, 32'h0);
        queue_request(OP_REMOVE, 8'd255, 32'hFFFF_FFFF);
        queue_request(OP_NONE,   8'd17,  32'hDEAD_BEEF);
        queue_request(OP_INSERT, 8'd255, 32'hFFFF_FFFF);
        queue_request(OP_INSERT, 8'd0,   32'h0000_0000);
        queue_request(OP_INSERT, 8'd1,   32'hA5A5_5A5A);
        queue_request(OP_INSERT, 8'd200, 32'h1234_5678);
        queue_request(OP_READ,   8'd0,   32'h0);
        queue_request(OP_READ,   8'd1,   32'h0);
        queue_request(OP_READ,   8'd2,   32'h0);
        queue_request(OP_READ,   8'd3,   32'h0);
        queue_request(OP_READ,   8'd4,   32'h0);
        queue_request(OP_READ,   8'd255, 32'h0);
        queue_request(OP_REMOVE, 8'd1,   32'h0);
        queue_request(OP_REMOVE, 8'd255, 32'h0);
        queue_request(OP_NONE,   8'd255, 32'hFFFF_FFFF);
        queue_request(OP_REMOVE, 8'd0,   32'h0);
        queue_request(OP_REMOVE, 8'd0,   32'h0);
        queue_request(OP_REMOVE, 8'd0,   32'h0);
        queue_request(OP_INSERT, 8'd128, 32'h5555_5555);
        queue_request(OP_INSERT, 8'd0,   32'hAAAA_AAAA);

        // Random bursts: fill-heavy bursts drive the list into full, drain-heavy
        // bursts empty it, balanced bursts shuffle entries in the middle.
        // Start with a fill burst so the full case shows up early.
        burst_mode = 0;
        while (request_q.size() < TOTAL_ITEMS)
        begin
            burst_len = $urandom_range(40, 120);
            if (burst_len > TOTAL_ITEMS - request_q.size())
                burst_len = TOTAL_ITEMS - request_q.size();
            repeat (burst_len)
            begin
                roll = $urandom_range(0, 99);
                case (burst_mode)
                    0:       pick = (roll < 80) ? OP_INSERT : (roll < 90) ? OP_REMOVE :
                                    (roll < 98) ? OP_READ : OP_NONE;
                    1:       pick = (roll < 75) ? OP_REMOVE : (roll < 85) ? OP_INSERT :
                                    (roll < 98) ? OP_READ : OP_NONE;
                    default: pick = (roll < 35) ? OP_INSERT : (roll < 65) ? OP_REMOVE :
                                    (roll < 97) ? OP_READ : OP_NONE;
                endcase
                queue_request(pick, pick_position(), pick_element());
            end
            burst_mode = $urandom_range(0, 2);
        end
        total_requests = request_q.size();

        // Hold reset at the start, then release it for good.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every item to go in and every reply to come back.
        while (request_q.size() > 0 || start || reply_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (reply_q.size() > 0)
            report_mismatch("replies never returned", ELEMENT_WIDTH'(reply_q.size()), '0);
        if (err_count == 0)
            $display("positional_list_engine verification clean");
        else
            $display("positional_list_engine verification failed");
        $finish;
    end

endmodule
